@@ hw/rtl/dpd_pkg.sv @@
`default_nettype none

package dpd_pkg;

	// fixed field widths
	localparam int WORD_W     = 32;
	localparam int LINE_W     = 5;
	localparam int DEB_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_ENABLE_MASK = 1'b1;

	// item opcodes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// one job: the lines to report, their levels and the report kind
	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] levels;
		logic              after_debounce;
	} job_t;

endpackage

`default_nettype wire

@@ hw/rtl/dpd_if.sv @@
`default_nettype none

interface dpd_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] flag_word;
	logic [31:0] pin_levels;

	modport source (output valid, output opcode, output flag_word, output pin_levels,
		input ready);
	modport sink (input valid, input opcode, input flag_word, input pin_levels,
		output ready);
endinterface

interface dpd_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] line;
	logic       level;
	logic       after_debounce;
	logic       last;

	modport source (output valid, output line, output level, output after_debounce,
		output last, input ready);
	modport sink (input valid, input line, input level, input after_debounce,
		input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dpd_front.sv @@
`default_nettype none

module dpd_front #(
	parameter int NUM_LINES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dpd_pkg::cfg_wr_t cfg,
	dpd_in_if.sink               in_ch,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output dpd_pkg::job_t        push_job
);
	import dpd_pkg::*;

	logic [DEB_W-1:0]     debounce_q;
	logic [NUM_LINES-1:0] enable_q;
	logic [NUM_LINES-1:0] waiting_q;
	logic [NUM_LINES-1:0] expected_q;
	logic [DEB_W-1:0]     count_q [NUM_LINES];

	logic                 accept;
	logic [NUM_LINES-1:0] flags;
	logic [NUM_LINES-1:0] levels;
	logic [NUM_LINES-1:0] expiring;
	logic [NUM_LINES-1:0] edge_hit;
	logic [NUM_LINES-1:0] report;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;
	assign flags       = in_ch.flag_word[NUM_LINES-1:0];
	assign levels      = in_ch.pin_levels[NUM_LINES-1:0];

	// classify every line of the incoming transaction
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			expiring[i] = waiting_q[i] && (count_q[i] <= DEB_W'(1));
		end
		edge_hit = flags & enable_q & ~waiting_q;
		if (in_ch.opcode == OP_EDGE) begin
			report = (debounce_q == '0) ? edge_hit : '0;
		end else begin
			report = expiring & enable_q & ~(levels ^ expected_q);
		end
	end

	// job towards the back end, only when something is reported
	always_comb begin
		push_valid              = accept && (report != '0);
		push_job.mask           = WORD_W'(report);
		push_job.levels         = WORD_W'(levels);
		push_job.after_debounce = (in_ch.opcode == OP_TICK);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
			enable_q   <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_DEBOUNCE_MS:      debounce_q <= cfg.data[DEB_W-1:0];
				REG_LINE_ENABLE_MASK: enable_q   <= cfg.data[NUM_LINES-1:0];
				default:              ;
			endcase
		end
	end

	// per-line waiting marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= '0;
		end else if (accept) begin
			if (in_ch.opcode == OP_EDGE) begin
				if (debounce_q != '0) begin
					waiting_q <= waiting_q | edge_hit;
				end
			end else begin
				waiting_q <= waiting_q & ~expiring;
			end
		end
	end

	// per-line latched level and debounce counter
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				if (in_ch.opcode == OP_EDGE) begin
					if (edge_hit[i] && (debounce_q != '0)) begin
						expected_q[i] <= levels[i];
						count_q[i]    <= debounce_q;
					end
				end else if (waiting_q[i]) begin
					count_q[i] <= expiring[i] ? '0 : count_q[i] - DEB_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dpd_queue.sv @@
`default_nettype none

module dpd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire dpd_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output dpd_pkg::job_t      pop_job
);
	import dpd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dpd_back.sv @@
`default_nettype none

module dpd_back #(
	parameter int NUM_LINES = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire dpd_pkg::job_t pop_job,
	dpd_out_if.source          out_ch
);
	import dpd_pkg::*;

	logic                 busy_q;
	logic [NUM_LINES-1:0] mask_q;
	logic [NUM_LINES-1:0] levels_q;
	logic                 deb_q;

	logic                 out_valid_q;
	logic [LINE_W-1:0]    line_q;
	logic                 level_q;
	logic                 after_q;
	logic                 last_q;

	logic                 can_load;
	logic [LINE_W-1:0]    pick;
	logic [NUM_LINES-1:0] rest;

	assign pop_ready = !busy_q;
	assign can_load  = !out_valid_q || out_ch.ready;
	assign rest      = mask_q & (mask_q - NUM_LINES'(1));

	// lowest pending line of the current job
	always_comb begin
		pick = '0;
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = LINE_W'(i);
			end
		end
	end

	// job register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			busy_q <= pop_valid;
		end else if (can_load) begin
			busy_q <= (rest != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (pop_valid) begin
				mask_q   <= pop_job.mask[NUM_LINES-1:0];
				levels_q <= pop_job.levels[NUM_LINES-1:0];
				deb_q    <= pop_job.after_debounce;
			end
		end else if (can_load) begin
			mask_q <= rest;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && busy_q) begin
			line_q  <= pick;
			level_q <= levels_q[pick];
			after_q <= deb_q;
			last_q  <= (rest == '0);
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.line           = line_q;
	assign out_ch.level          = level_q;
	assign out_ch.after_debounce = after_q;
	assign out_ch.last           = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/debounced_pin_event_dispatcher.sv @@
// Debounced pin event dispatcher for up to NUM_LINES interrupt lines. An edge
// transaction (opcode 0) carries pending flags and pin levels; enabled, flagged,
// non-waiting lines either report at once (debounce_ms = 0) or latch their level
// and start a countdown. A tick transaction (opcode 1) counts every waiting line
// down and reports expiring, enabled lines whose level still matches. Reports
// leave in ascending line order, one per cycle while the output is not stalled,
// with last set on the final report of each transaction; transactions that
// report nothing produce no output. The front end takes one transaction per
// cycle while its two-entry job queue has room. The back end loads a job into
// its job register, then emits one report per cycle while the output is not
// stalled, and takes the next job only once the final report is loaded. Jobs
// pass the queue, the job register and the output register; output stalls
// hold the back end and, once the queue is full, the input. Configuration is
// written via cfg_we/cfg_index/cfg_wdata (index 0: debounce_ms, index 1:
// line_enable_mask); the user must write it only while the block is idle, and
// the block itself does not enforce it. No clearing pass after reset is needed.
`default_nettype none

module debounced_pin_event_dispatcher #(
	parameter int NUM_LINES = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	dpd_in_if.sink                              in_ch,
	dpd_out_if.source                           out_ch
);
	import dpd_pkg::*;

	cfg_wr_t cfg;
	logic    push_valid;
	logic    push_ready;
	job_t    push_job;
	logic    pop_valid;
	logic    pop_ready;
	job_t    pop_job;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_wdata;

	// classification and per-line state
	dpd_front #(
		.NUM_LINES (NUM_LINES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// job queue
	dpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// report sequencing
	dpd_back #(
		.NUM_LINES (NUM_LINES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

@@ hw/rtl/dpd_checker.sv @@
`default_nettype none

module dpd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [dpd_pkg::LINE_W-1:0]  out_line,
	input wire logic                        out_level,
	input wire logic                        out_after,
	input wire logic                        out_last
);
	import dpd_pkg::*;

	logic              prev_last_q;
	logic [LINE_W-1:0] prev_line_q;
	logic              prev_after_q;
	logic              out_take;

	assign out_take = out_valid && out_ready;

	// remember the previous report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q  <= 1'b1;
			prev_line_q  <= '0;
			prev_after_q <= 1'b0;
		end else if (out_take) begin
			prev_last_q  <= out_last;
			prev_line_q  <= out_line;
			prev_after_q <= out_after;
		end
	end

	// a stalled report holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_line) && $stable(out_level)
			&& $stable(out_after) && $stable(out_last))
		else $error("stalled report changed");

	// no report straight out of reset
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("report right after reset");

	// reports of one transaction rise in line order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !prev_last_q |-> out_line > prev_line_q)
		else $error("reports out of line order");

	// reports of one transaction share their kind
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !prev_last_q |-> out_after == prev_after_q)
		else $error("report kind changed within a transaction");

endmodule

bind debounced_pin_event_dispatcher dpd_checker u_dpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_line  (out_ch.line),
	.out_level (out_ch.level),
	.out_after (out_ch.after_debounce),
	.out_last  (out_ch.last)
);

`default_nettype wire

@@ test/dpd_report_checker.sv @@
`timescale 1ns / 100ps

module dpd_report_checker #(
	parameter int NUM_LINES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	dpd_in_if                              in_mon,
	dpd_out_if                             out_mon,
	output int                             fail_count,
	output int                             pending
);
	import dpd_pkg::*;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              level;
		logic              after_debounce;
		logic              last;
	} report_t;

	// shadow of the register file
	logic [DEB_W-1:0]     debounce_ticks;
	logic [WORD_W-1:0]    handler_mask;

	// shadow of the per-line debounce state
	logic [NUM_LINES-1:0] line_waiting;
	logic [NUM_LINES-1:0] latched_level;
	logic [DEB_W-1:0]     ms_left [NUM_LINES];

	report_t expected_reports [$];
	int      mismatches = 0;
	int      queued = 0;

	assign fail_count = mismatches;
	assign pending    = queued;

	task automatic report_mismatch(input string what);
		$display("%0t ns: report mismatch, %s", $time, what);
		mismatches++;
	endtask

	function automatic void queue_report(input int line, input logic level, input logic deb);
		report_t r;
		r.line           = LINE_W'(line);
		r.level          = level;
		r.after_debounce = deb;
		r.last           = 1'b0;
		expected_reports.push_back(r);
	endfunction

	// works out the reports caused by one input transaction and updates the shadow state
	function automatic void predict_reports(input logic op, input logic [WORD_W-1:0] flags,
		input logic [WORD_W-1:0] levels);
		int      first_new;
		report_t r;
		first_new = expected_reports.size();
		for (int i = 0; i < NUM_LINES; i++) begin
			if (op == OP_EDGE) begin
				if (flags[i] && handler_mask[i] && !line_waiting[i]) begin
					if (debounce_ticks != '0) begin
						line_waiting[i]  = 1'b1;
						latched_level[i] = levels[i];
						ms_left[i]       = debounce_ticks;
					end else begin
						queue_report(i, levels[i], 1'b0);
					end
				end
			end else if (line_waiting[i]) begin
				// counter runs down even on disabled lines
				if (ms_left[i] > DEB_W'(1)) begin
					ms_left[i] = ms_left[i] - DEB_W'(1);
				end else begin
					ms_left[i]      = '0;
					line_waiting[i] = 1'b0;
					if (handler_mask[i] && levels[i] == latched_level[i])
						queue_report(i, levels[i], 1'b1);
				end
			end
		end
		// mark the final report of this transaction
		if (expected_reports.size() > first_new) begin
			r = expected_reports.pop_back();
			r.last = 1'b1;
			expected_reports.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			debounce_ticks = '0;
			handler_mask   = '0;
			line_waiting   = '0;
			latched_level  = '0;
			for (int i = 0; i < NUM_LINES; i++)
				ms_left[i] = '0;
			expected_reports.delete();
		end else begin
			// compare an accepted report with the oldest expectation
			if (out_mon.valid && out_mon.ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("report for line %0d with none expected",
						out_mon.line));
				end else begin
					want = expected_reports.pop_front();
					if (out_mon.line !== want.line)
						report_mismatch($sformatf("line: got %0d, expected %0d",
							out_mon.line, want.line));
					if (out_mon.level !== want.level)
						report_mismatch($sformatf("line %0d level: got %0b, expected %0b",
							want.line, out_mon.level, want.level));
					if (out_mon.after_debounce !== want.after_debounce)
						report_mismatch($sformatf(
							"line %0d after_debounce: got %0b, expected %0b",
							want.line, out_mon.after_debounce, want.after_debounce));
					if (out_mon.last !== want.last)
						report_mismatch($sformatf("line %0d last: got %0b, expected %0b",
							want.line, out_mon.last, want.last));
				end
			end

			// register writes
			if (cfg_we) begin
				if (cfg_index == REG_DEBOUNCE_MS)
					debounce_ticks = cfg_wdata[DEB_W-1:0];
				else if (cfg_index == REG_LINE_ENABLE_MASK)
					handler_mask = cfg_wdata[WORD_W-1:0];
			end

			// predict from each accepted input transaction
			if (in_mon.valid && in_mon.ready)
				predict_reports(in_mon.opcode, in_mon.flag_word, in_mon.pin_levels);
		end
		queued = expected_reports.size();
	end

endmodule

@@ test/debounced_pin_event_dispatcher_test.sv @@
`timescale 1ns / 100ps

module debounced_pin_event_dispatcher_test;
	import dpd_pkg::*;

	localparam int NUM_LINES      = 32;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	dpd_in_if  in_ch ();
	dpd_out_if out_ch ();

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	bit src_gaps;
	bit snk_stalls;

	debounced_pin_event_dispatcher #(
		.NUM_LINES (NUM_LINES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	dpd_report_checker #(
		.NUM_LINES (NUM_LINES)
	) report_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// report sink with bursts of back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (snk_stalls && stall_left == 0 && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 15);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic op, input logic [WORD_W-1:0] flags,
		input logic [WORD_W-1:0] levels);
		int gap;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.opcode     <= op;
		in_ch.flag_word  <= flags;
		in_ch.pin_levels <= levels;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// let every expected report arrive, then give the back end time to finish silent work
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [DEB_W-1:0] deb, input logic [WORD_W-1:0] mask);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEBOUNCE_MS;
		cfg_wdata <= CFG_DATA_W'(deb);
		@(posedge clk);
		cfg_index <= REG_LINE_ENABLE_MASK;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic              op;
		logic [WORD_W-1:0] flags;
		logic [WORD_W-1:0] levels;
		logic [WORD_W-1:0] pins;
		logic [DEB_W-1:0]  deb;
		logic [WORD_W-1:0] mask;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_DEBOUNCE_MS;
		cfg_wdata        = '0;
		in_ch.valid      = 1'b0;
		in_ch.opcode     = OP_EDGE;
		in_ch.flag_word  = '0;
		in_ch.pin_levels = '0;
		src_gaps         = 1'b1;
		snk_stalls       = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// immediate reports on every line
		set_config('0, '1);
		send_item(OP_EDGE, '1, '1);
		send_item(OP_EDGE, '0, $urandom);
		send_item(OP_EDGE, '1, '0);
		send_item(OP_EDGE, 32'h8000_0001, 32'h8000_0000);
		// tick with flags set and nothing waiting
		send_item(OP_TICK, '1, '1);
		drain();

		// shortest debounce on the lower half, flags on waiting or disabled lines ignored
		set_config(16'd1, 32'h0000_FFFF);
		send_item(OP_EDGE, '1, 32'hAAAA_5555);
		send_item(OP_EDGE, '1, '0);
		send_item(OP_TICK, '0, 32'hAAAA_5555);
		send_item(OP_EDGE, 32'h0000_000F, 32'h0000_000F);
		send_item(OP_TICK, '1, 32'h0000_0005);
		drain();

		// lines disabled and debounce changed while waiting
		set_config(16'd3, '1);
		send_item(OP_EDGE, '1, 32'h1234_5678);
		drain();
		set_config(16'd2, 32'h0F0F_0F0F);
		send_item(OP_TICK, $urandom, 32'h1234_5678);
		send_item(OP_EDGE, '1, 32'h1234_5678);
		send_item(OP_TICK, '0, 32'h1234_5678);
		send_item(OP_TICK, '1, 32'h1234_5678 ^ 32'h0000_00FF);
		send_item(OP_EDGE, '1, $urandom);
		drain();

		// longest debounce on the top line
		set_config('1, '1);
		send_item(OP_EDGE, 32'h8000_0000, '1);
		drain();

		// random phases, each with its own setting; the last ones run without idling
		pins = $urandom;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 4))
				0:       deb = '0;
				1:       deb = 16'd1;
				default: deb = DEB_W'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 5))
				0:       mask = '0;
				1:       mask = '1;
				default: mask = $urandom;
			endcase
			set_config(deb, mask);
			src_gaps   = phase < RANDOM_PHASES - 2 && $urandom_range(0, 3) != 0;
			snk_stalls = phase < RANDOM_PHASES - 2 && $urandom_range(0, 3) != 0;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 1) == 0) ? OP_EDGE : OP_TICK;
				case ($urandom_range(0, 4))
					0:       flags = '1;
					1:       flags = 32'h1 << $urandom_range(0, 31);
					default: flags = $urandom;
				endcase
				// pins mostly hold their level so debounced lines usually match
				if ($urandom_range(0, 7) == 0)
					pins ^= $urandom & $urandom;
				levels = pins;
				if ($urandom_range(0, 3) == 0)
					levels ^= 32'h1 << $urandom_range(0, 31);
				send_item(op, flags, levels);
			end
			drain();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_if.sv
hw/rtl/dpd_front.sv
hw/rtl/dpd_queue.sv
hw/rtl/dpd_back.sv
hw/rtl/debounced_pin_event_dispatcher.sv
hw/rtl/dpd_checker.sv
test/dpd_report_checker.sv
test/debounced_pin_event_dispatcher_test.sv
